### design/fopq_pkg.sv
// ----------------------------------------------------------------------------
// fopq_pkg
// Shared types and codes of the task queue: request functions, result
// status codes, register indexes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package fopq_pkg;

  // fixed field widths
  localparam int STATUS_W   = 3;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int MODE_W     = 2;

  // request function
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // dispatch mode that picks the lowest priority value
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 1'b1;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ      = 3'd0,
    ST_FULL     = 3'd1,
    ST_DISABLED = 3'd2,
    ST_DEQ      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic scan;
    logic remove;
    logic move;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic deq_fetch;
    logic scan_more;
    logic move_needed;
    logic move_done;
    logic out_free;
  } dp_sts_t;

endpackage

### design/fopq_if.sv
// ----------------------------------------------------------------------------
// fopq_if
// Valid/ready channels of the task queue: request in, result out.
// ----------------------------------------------------------------------------
interface fopq_in_if #(
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 3
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [TAG_BITS-1:0]  task_tag;
  logic [PRIO_BITS-1:0] task_priority;

  modport source (output valid, func, task_tag, task_priority, input ready);
  modport sink   (input valid, func, task_tag, task_priority, output ready);
endinterface

interface fopq_out_if #(
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 3
);
  logic                          valid;
  logic                          ready;
  logic [fopq_pkg::STATUS_W-1:0] status;
  logic [TAG_BITS-1:0]           out_tag;
  logic [PRIO_BITS-1:0]          out_priority;
  logic [fopq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

### design/fifo_or_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// fifo_or_priority_task_queue_top
// Task ready queue with first-come or lowest-priority-value dispatch.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and a new one is taken while the last
// result still waits in the output register. Tasks sit in a single-port-read
// RAM used as a circular buffer, so the RAM read port sets the timing. A
// dequeue reads the oldest task, or in priority mode scans all n held tasks,
// then removes the pick and closes the gap when it is neither the oldest nor
// the newest task. dispatch_mode and accept_enable are to be written by the
// user through the plain write port only while the queue is idle; the block
// itself does not enforce it. The store needs no clearing after reset.
module fifo_or_priority_task_queue_top #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fopq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fopq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fopq_in_if.sink                         req_i,
  fopq_out_if.source                      res_o
);

  fopq_pkg::dp_cmd_t cmd;
  fopq_pkg::dp_sts_t sts;

  // sequencer
  fopq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  fopq_dp #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (req_i.func),
    .task_tag_i      (req_i.task_tag),
    .task_priority_i (req_i.task_priority),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .status_o        (res_o.status),
    .out_tag_o       (res_o.out_tag),
    .out_priority_o  (res_o.out_priority),
    .occupancy_o     (res_o.occupancy),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

### design/fopq_ram.sv
// ----------------------------------------------------------------------------
// fopq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fopq_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/fopq_ctrl.sv
// ----------------------------------------------------------------------------
// fopq_ctrl
// Sequencer of the task queue: accept, decide, scan, remove, compact, result.
// ----------------------------------------------------------------------------
module fopq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fopq_pkg::dp_sts_t sts_i,
  output fopq_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = sts_i.deq_fetch ? S_SCAN : S_RESULT;
      end
      S_SCAN: begin
        if (!sts_i.scan_more) state_d = S_REMOVE;
      end
      S_REMOVE: begin
        state_d = sts_i.move_needed ? S_MOVE : S_RESULT;
      end
      S_MOVE: begin
        if (sts_i.move_done) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.accept  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.decide  = (state_q == S_DECIDE);
  assign cmd_o.scan    = (state_q == S_SCAN);
  assign cmd_o.remove  = (state_q == S_REMOVE);
  assign cmd_o.move    = (state_q == S_MOVE) && !sts_i.move_done;
  assign cmd_o.load    = (state_q == S_RESULT) && sts_i.out_free;

endmodule

### design/fopq_dp.sv
// ----------------------------------------------------------------------------
// fopq_dp
// Datapath of the task queue: circular task store, config registers,
// minimum scan, gap compaction and the result register.
// ----------------------------------------------------------------------------
module fopq_dp #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config
  input  logic                              cfg_we_i,
  input  logic [fopq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fopq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request payload
  input  logic                              func_i,
  input  logic [TAG_BITS-1:0]               task_tag_i,
  input  logic [PRIO_BITS-1:0]              task_priority_i,
  // result
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fopq_pkg::STATUS_W-1:0]     status_o,
  output logic [TAG_BITS-1:0]               out_tag_o,
  output logic [PRIO_BITS-1:0]              out_priority_o,
  output logic [fopq_pkg::OCC_W-1:0]        occupancy_o,
  // control
  input  fopq_pkg::dp_cmd_t                 cmd_i,
  output fopq_pkg::dp_sts_t                 sts_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TAG_BITS + PRIO_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // logical slot to physical address, head + slot wraps once at most
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [CW-1:0] slot);
    logic [CW:0] sum;
    sum = {{(CW + 1 - IW){1'b0}}, head} + {1'b0, slot};
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[IW-1:0];
  endfunction

  // config registers
  logic [fopq_pkg::MODE_W-1:0] mode_q;
  logic                        accept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      accept_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fopq_pkg::CFG_MODE:   mode_q   <= cfg_data_i;
        fopq_pkg::CFG_ACCEPT: accept_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // queue control registers
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] wr_q, wr_d;
  logic          pend_q, pend_d;
  logic          first_q, first_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic                 func_q;
  logic [TAG_BITS-1:0]  tag_in_q;
  logic [PRIO_BITS-1:0] prio_in_q;
  logic [TAG_BITS-1:0]  best_tag_q, best_tag_d;
  logic [PRIO_BITS-1:0] best_prio_q, best_prio_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  fopq_pkg::status_e    res_status_q, res_status_d;
  logic [TAG_BITS-1:0]  res_tag_q, res_tag_d;
  logic [PRIO_BITS-1:0] res_prio_q, res_prio_d;
  fopq_pkg::status_e    out_status_q;
  logic [TAG_BITS-1:0]  out_tag_q;
  logic [PRIO_BITS-1:0] out_prio_q;
  logic [fopq_pkg::OCC_W-1:0] out_occ_q;

  // ram ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [TAG_BITS-1:0]  rd_tag;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [CW-1:0]        scan_len;
  logic [CW-1:0]        j_prev;
  logic [CW-1:0]        best_idx_ext;
  logic [CW+fopq_pkg::OCC_W-1:0] occ_ext;

  assign rd_tag       = rdata[EW-1:PRIO_BITS];
  assign rd_prio      = rdata[PRIO_BITS-1:0];
  assign scan_len     = (mode_q == fopq_pkg::MODE_PRIO) ? count_q : ONE_C;
  assign j_prev       = j_q - ONE_C;
  assign best_idx_ext = {{(CW - IW){1'b0}}, best_idx_q};
  assign occ_ext      = {{fopq_pkg::OCC_W{1'b0}}, count_q};

  fopq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status to controller
  assign sts_o.deq_fetch   = (func_q == fopq_pkg::FUNC_DEQ) && (count_q != '0);
  assign sts_o.scan_more   = (j_q < scan_len);
  assign sts_o.move_needed = (best_idx_q != '0) && (best_idx_ext != (count_q - ONE_C));
  assign sts_o.move_done   = !pend_q && (j_q > count_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // datapath step
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    j_d          = j_q;
    wr_d         = wr_q;
    pend_d       = pend_q;
    first_d      = first_q;
    best_tag_d   = best_tag_q;
    best_prio_d  = best_prio_q;
    best_idx_d   = best_idx_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_prio_d   = res_prio_q;
    we           = 1'b0;
    waddr        = phys(head_q, count_q);
    wdata        = {tag_in_q, prio_in_q};
    re           = 1'b0;
    raddr        = phys(head_q, j_q);

    // classify the request, append or start the fetch
    if (cmd_i.decide) begin
      res_tag_d  = '0;
      res_prio_d = '0;
      if (func_q == fopq_pkg::FUNC_ENQ) begin
        if (!accept_q) begin
          res_status_d = fopq_pkg::ST_DISABLED;
        end else if (count_q == DEPTH_C) begin
          res_status_d = fopq_pkg::ST_FULL;
        end else begin
          we           = 1'b1;
          count_d      = count_q + ONE_C;
          res_status_d = fopq_pkg::ST_ENQ;
        end
      end else if (count_q == '0) begin
        res_status_d = fopq_pkg::ST_EMPTY;
      end else begin
        re      = 1'b1;
        raddr   = head_q;
        j_d     = ONE_C;
        first_d = 1'b1;
      end
    end

    // one slot per cycle, strict less keeps the earliest of equals
    if (cmd_i.scan) begin
      if (first_q || (rd_prio < best_prio_q)) begin
        best_tag_d  = rd_tag;
        best_prio_d = rd_prio;
        best_idx_d  = j_prev[IW-1:0];
      end
      first_d = 1'b0;
      if (j_q < scan_len) begin
        re  = 1'b1;
        j_d = j_q + ONE_C;
      end
    end

    // hand out the pick, drop the head or prepare the compaction
    if (cmd_i.remove) begin
      res_status_d = fopq_pkg::ST_DEQ;
      res_tag_d    = best_tag_q;
      res_prio_d   = best_prio_q;
      count_d      = count_q - ONE_C;
      if (best_idx_q == '0) begin
        head_d = phys(head_q, ONE_C);
      end else begin
        j_d    = best_idx_ext + ONE_C;
        wr_d   = best_idx_ext;
        pend_d = 1'b0;
      end
    end

    // slide the tail down by one slot, read and write overlapped
    if (cmd_i.move) begin
      if (pend_q) begin
        we    = 1'b1;
        waddr = phys(head_q, wr_q);
        wdata = rdata;
        wr_d  = wr_q + ONE_C;
      end
      if (j_q <= count_q) begin
        re     = 1'b1;
        j_d    = j_q + ONE_C;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      j_q         <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      j_q         <= j_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q    <= func_i;
      tag_in_q  <= task_tag_i;
      prio_in_q <= task_priority_i;
    end
    best_tag_q   <= best_tag_d;
    best_prio_q  <= best_prio_d;
    best_idx_q   <= best_idx_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_prio_q   <= res_prio_d;
    if (cmd_i.load) begin
      out_status_q <= res_status_q;
      out_tag_q    <= res_tag_q;
      out_prio_q   <= res_prio_q;
      out_occ_q    <= occ_ext[fopq_pkg::OCC_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_tag_o      = out_tag_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = out_occ_q;

endmodule

### design/fopq_checker.sv
// ----------------------------------------------------------------------------
// fopq_checker
// Port-level checks of the task queue results, bound to the top level.
// ----------------------------------------------------------------------------
module fopq_checker #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 16,
  parameter int PRIO_BITS = 3
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [fopq_pkg::STATUS_W-1:0]  res_status_i,
  input logic [TAG_BITS-1:0]            res_tag_i,
  input logic [PRIO_BITS-1:0]           res_prio_i,
  input logic [fopq_pkg::OCC_W-1:0]     res_occ_i
);

  localparam logic [fopq_pkg::OCC_W-1:0] FULL_OCC = fopq_pkg::OCC_W'(DEPTH);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i) &&
      $stable(res_tag_i) && $stable(res_prio_i) && $stable(res_occ_i))
    else $error("result changed while stalled");

  // only a dequeued task carries a tag and a priority
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i != fopq_pkg::ST_DEQ) |->
      (res_tag_i == '0) && (res_prio_i == '0))
    else $error("tag or priority set on a non-dequeue result");

  // an empty answer reports an empty queue
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == fopq_pkg::ST_EMPTY) |-> (res_occ_i == '0))
    else $error("empty status with tasks held");

  // a full drop reports a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == fopq_pkg::ST_FULL) |-> (res_occ_i == FULL_OCC))
    else $error("full status without a full queue");

endmodule

bind fifo_or_priority_task_queue_top fopq_checker #(
  .DEPTH     (DEPTH),
  .TAG_BITS  (TAG_BITS),
  .PRIO_BITS (PRIO_BITS)
) u_fopq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_tag_i    (res_o.out_tag),
  .res_prio_i   (res_o.out_priority),
  .res_occ_i    (res_o.occupancy)
);
